// File: rtl/websocket_frame_parser_assert.svh
// Assertion macros for the frame parser.
`ifndef WEBSOCKET_FRAME_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_PARSER_ASSERT_SVH

// Check while out of reset.
`define WFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define WFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/wfp_pkg.sv
`timescale 1ns / 1ps

package wfp_pkg;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

endpackage

// File: rtl/websocket_frame_parser.sv
// Result: a byte that completes a header or carries payload shows in the output register in the next cycle.
// Throughput: one byte per cycle; in_ready drops only while a result is
// held and out_ready is low.
// Reset (rst_n low, synchronous): parser returns to the first header byte,
// all header state and the output valid clear.
`timescale 1ns / 1ps
`include "websocket_frame_parser_assert.svh"

module websocket_frame_parser
  import wfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic        out_fin,
  output logic [3:0]  out_opcode,
  output logic        out_masked,
  output logic [63:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic [63:0] out_offset,
  output logic        out_last
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic        fin_flag_r, fin_flag_nxt;
  logic [3:0]  op_code_r, op_code_nxt;
  logic        mask_flag_r, mask_flag_nxt;
  logic [6:0]  length_code_r, length_code_nxt;
  logic [63:0] frame_length_r, frame_length_nxt;
  logic [63:0] position_r, position_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic        out_fin_r, out_fin_nxt;
  logic [3:0]  out_opcode_r, out_opcode_nxt;
  logic        out_masked_r, out_masked_nxt;
  logic [63:0] out_length_r, out_length_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [63:0] out_offset_r, out_offset_nxt;
  logic        out_last_r, out_last_nxt;

  logic        accept;
  logic        emit;
  logic        emit_header;
  logic [3:0]  count_inc;
  logic [3:0]  ext_need;
  logic [63:0] position_inc;
  logic [7:0]  key_byte;

  logic        payload_accept;
  logic        out_is_payload;
  logic        last_at_end;
  logic        idle_state;

  assign in_ready     = !out_valid_r || out_ready;
  assign accept       = in_valid && in_ready;
  assign count_inc    = byte_count_r + 4'd1;
  assign ext_need     = (length_code_r == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
  assign position_inc = position_r + 64'd1;

  always_comb begin
    case (position_r[1:0])
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    fin_flag_nxt     = fin_flag_r;
    op_code_nxt      = op_code_r;
    mask_flag_nxt    = mask_flag_r;
    length_code_nxt  = length_code_r;
    frame_length_nxt = frame_length_r;
    position_nxt     = position_r;
    mask_key_nxt     = mask_key_r;
    emit             = 1'b0;
    emit_header      = 1'b0;
    out_kind_nxt     = KIND_HEADER;
    out_byte_nxt     = 8'd0;
    out_offset_nxt   = 64'd0;
    out_last_nxt     = 1'b0;

    case (phase_r)
      PH_SECOND: begin
        mask_flag_nxt   = in_byte_in[7];
        length_code_nxt = in_byte_in[6:0];
        mask_key_nxt    = 32'd0;
        byte_count_nxt  = 4'd0;
        if (in_byte_in[6:0] == LEN_CODE_16 || in_byte_in[6:0] == LEN_CODE_64) begin
          frame_length_nxt = 64'd0;
          phase_nxt        = PH_EXTLEN;
        end else begin
          frame_length_nxt = {57'd0, in_byte_in[6:0]};
          if (in_byte_in[7]) begin
            phase_nxt = PH_MASK;
          end else begin
            emit_header = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        frame_length_nxt = {frame_length_r[55:0], in_byte_in};
        byte_count_nxt   = count_inc;
        if (count_inc >= ext_need) begin
          byte_count_nxt = 4'd0;
          if (mask_flag_r) begin
            phase_nxt = PH_MASK;
          end else begin
            emit_header = 1'b1;
          end
        end
      end
      PH_MASK: begin
        mask_key_nxt   = {mask_key_r[23:0], in_byte_in};
        byte_count_nxt = count_inc;
        if (count_inc >= KEY_BYTES) begin
          emit_header = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        emit           = 1'b1;
        out_kind_nxt   = KIND_PAYLOAD;
        out_byte_nxt   = in_byte_in ^ key_byte;
        out_offset_nxt = position_r;
        position_nxt   = position_inc;
        if (position_inc == frame_length_r) begin
          out_last_nxt = 1'b1;
          phase_nxt    = PH_FIRST;
        end
      end
      default: begin
        fin_flag_nxt = in_byte_in[7];
        op_code_nxt  = in_byte_in[3:0];
        phase_nxt    = PH_SECOND;
      end
    endcase

    if (emit_header) begin
      emit           = 1'b1;
      position_nxt   = 64'd0;
      byte_count_nxt = 4'd0;
      out_last_nxt   = (frame_length_nxt == 64'd0);
      phase_nxt      = (frame_length_nxt == 64'd0) ? PH_FIRST : PH_PAYLOAD;
    end

    out_fin_nxt    = fin_flag_nxt;
    out_opcode_nxt = op_code_nxt;
    out_masked_nxt = mask_flag_nxt;
    out_length_nxt = frame_length_nxt;

    if (accept) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_FIRST;
      byte_count_r   <= 4'd0;
      fin_flag_r     <= 1'b0;
      op_code_r      <= 4'd0;
      mask_flag_r    <= 1'b0;
      length_code_r  <= 7'd0;
      frame_length_r <= 64'd0;
      position_r     <= 64'd0;
      mask_key_r     <= 32'd0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r        <= phase_nxt;
        byte_count_r   <= byte_count_nxt;
        fin_flag_r     <= fin_flag_nxt;
        op_code_r      <= op_code_nxt;
        mask_flag_r    <= mask_flag_nxt;
        length_code_r  <= length_code_nxt;
        frame_length_r <= frame_length_nxt;
        position_r     <= position_nxt;
        mask_key_r     <= mask_key_nxt;
      end
      if (accept && emit) begin
        out_kind_r   <= out_kind_nxt;
        out_fin_r    <= out_fin_nxt;
        out_opcode_r <= out_opcode_nxt;
        out_masked_r <= out_masked_nxt;
        out_length_r <= out_length_nxt;
        out_byte_r   <= out_byte_nxt;
        out_offset_r <= out_offset_nxt;
        out_last_r   <= out_last_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_fin            = out_fin_r;
  assign out_opcode         = out_opcode_r;
  assign out_masked         = out_masked_r;
  assign out_payload_length = out_length_r;
  assign out_payload_byte   = out_byte_r;
  assign out_offset         = out_offset_r;
  assign out_last           = out_last_r;

  assign payload_accept = accept && (phase_r == PH_PAYLOAD);
  assign out_is_payload = out_valid_r && (out_kind_r == KIND_PAYLOAD);
  assign last_at_end    = (out_offset_r + 64'd1 == out_length_r);
  assign idle_state     = (phase_r == PH_FIRST) && !out_valid_r;

  `WFP_ASSERT(a_payload_gives_result, payload_accept |=> out_is_payload, "no payload result")
  `WFP_ASSERT(a_payload_nonempty, out_is_payload |-> (out_length_r != 64'd0), "empty payload")
  `WFP_ASSERT(a_last_offset, (out_is_payload && out_last_r) |-> last_at_end, "last misplaced")
  `WFP_ASSERT_ALWAYS(a_reset_state, !rst_n |=> idle_state, "bad reset state")

endmodule

// File: bench/websocket_frame_parser_tb.sv
`timescale 1ns / 1ps

module websocket_frame_parser_tb;
  import wfp_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST_BYTE  = 3'd0,
    PH_SECOND_BYTE = 3'd1,
    PH_EXT_LEN     = 3'd2,
    PH_MASK_KEY    = 3'd3,
    PH_PAYLOAD     = 3'd4
  } parse_phase_t;

  typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_t;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic [63:0] offset;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic        out_fin;
  logic [3:0]  out_opcode;
  logic        out_masked;
  logic [63:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic [63:0] out_offset;
  logic        out_last;

  // predictor state
  parse_phase_t parse_phase = PH_FIRST_BYTE;
  logic [3:0]   ext_count = '0;
  logic         hdr_fin = 1'b0;
  logic [3:0]   hdr_opcode = '0;
  logic         hdr_masked = 1'b0;
  logic [6:0]   hdr_len_code = '0;
  logic [63:0]  hdr_length = '0;
  logic [63:0]  payload_pos = '0;
  logic [31:0]  hdr_key = '0;

  frame_result_t decoded_results[$];

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned header_results = 0;
  logic        send_idle = 1'b1;
  logic        recv_idle = 1'b1;
  int unsigned hold_off_cycles = 0;
  logic        sink_holding = 1'b0;

  websocket_frame_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_fin            (out_fin),
    .out_opcode         (out_opcode),
    .out_masked         (out_masked),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_offset         (out_offset),
    .out_last           (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic emit_header();
    frame_result_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.fin = hdr_fin;
    r.opcode = hdr_opcode;
    r.masked = hdr_masked;
    r.payload_length = hdr_length;
    r.last = (hdr_length == 64'd0);
    decoded_results.push_back(r);
    payload_pos = '0;
    ext_count = '0;
    parse_phase = (hdr_length == 64'd0) ? PH_FIRST_BYTE : PH_PAYLOAD;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0] key_byte;
    case (parse_phase)
      PH_SECOND_BYTE: begin
        hdr_masked = b[7];
        hdr_len_code = b[6:0];
        hdr_key = '0;
        ext_count = '0;
        if (hdr_len_code == LEN_CODE_16 || hdr_len_code == LEN_CODE_64) begin
          hdr_length = '0;
          parse_phase = PH_EXT_LEN;
        end else begin
          hdr_length = {57'd0, hdr_len_code};
          if (hdr_masked) parse_phase = PH_MASK_KEY;
          else emit_header();
        end
      end
      PH_EXT_LEN: begin
        hdr_length = {hdr_length[55:0], b};
        ext_count = ext_count + 4'd1;
        if (ext_count >= ((hdr_len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64)) begin
          ext_count = '0;
          if (hdr_masked) parse_phase = PH_MASK_KEY;
          else emit_header();
        end
      end
      PH_MASK_KEY: begin
        hdr_key = {hdr_key[23:0], b};
        ext_count = ext_count + 4'd1;
        if (ext_count >= KEY_BYTES) emit_header();
      end
      PH_PAYLOAD: begin
        key_byte = 8'(hdr_key >> {~payload_pos[1:0], 3'b000});
        r.kind = KIND_PAYLOAD;
        r.fin = hdr_fin;
        r.opcode = hdr_opcode;
        r.masked = hdr_masked;
        r.payload_length = hdr_length;
        r.payload_byte = b ^ key_byte;
        r.offset = payload_pos;
        payload_pos = payload_pos + 64'd1;
        r.last = (payload_pos == hdr_length);
        if (r.last) parse_phase = PH_FIRST_BYTE;
        decoded_results.push_back(r);
      end
      default: begin
        hdr_fin = b[7];
        hdr_opcode = b[3:0];
        parse_phase = PH_SECOND_BYTE;
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte_in);
        bytes_sent++;
      end
      if (out_valid && out_ready) begin
        if (decoded_results.size() == 0) begin
          $error("unexpected result: kind %0b offset %0h", out_kind, out_offset);
          mismatches++;
        end else begin
          want = decoded_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_kind));
          check_field("fin", 64'(want.fin), 64'(out_fin));
          check_field("opcode", 64'(want.opcode), 64'(out_opcode));
          check_field("masked", 64'(want.masked), 64'(out_masked));
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("payload_byte", 64'(want.payload_byte), 64'(out_payload_byte));
          check_field("offset", want.offset, out_offset);
          check_field("last", 64'(want.last), 64'(out_last));
          results_checked++;
          if (want.kind == KIND_HEADER) header_results++;
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned burst;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        burst = hold_off_cycles;
        hold_off_cycles = 0;
        sink_holding = 1'b1;
        out_ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 18);
        out_ready <= 1'b0;
      end else begin
        burst = $urandom_range(1, 24);
        out_ready <= 1'b1;
      end
      repeat (burst) @(posedge clk);
      sink_holding = 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] head, input logic mask, input len_enc_t enc,
                            input logic [63:0] len, input logic [31:0] key,
                            input int unsigned n_bytes);
    send_byte(head);
    case (enc)
      ENC_SHORT: send_byte({mask, len[6:0]});
      ENC_16: begin
        send_byte({mask, LEN_CODE_16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mask) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int unsigned i = 0; i < n_bytes; i++) send_byte(8'($urandom_range(0, 255)));
    frames_sent++;
  endtask

  task automatic test_directed();
    send_frame(8'h81, 1'b0, ENC_SHORT, 64'd1, 32'h0, 1);
    send_frame(8'h89, 1'b0, ENC_SHORT, 64'd0, 32'h0, 0);
    send_frame(8'h7A, 1'b1, ENC_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
    send_frame(8'hFF, 1'b1, ENC_16, 64'd5, 32'hA1B2_C3D4, 5);
  endtask

  task automatic test_random_frames(input int unsigned byte_goal, input logic vary_idle);
    logic [63:0]  len;
    len_enc_t     enc;
    int unsigned  pick;
    send_idle = vary_idle;
    recv_idle = vary_idle;
    while (bytes_sent < byte_goal) begin
      if (vary_idle && $urandom_range(0, 5) == 0) begin
        send_idle = 1'($urandom_range(0, 1));
        recv_idle = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        enc = ENC_SHORT;
        len = 64'((pick == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12));
      end else if (pick < 9) begin
        enc = ENC_16;
        len = 64'(($urandom_range(0, 7) == 0) ? $urandom_range(126, 300)
                                               : $urandom_range(0, 20));
      end else begin
        enc = ENC_64;
        len = 64'($urandom_range(0, 16));
      end
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), enc, len, $urandom(),
                 32'(len));
    end
  endtask

  task automatic test_output_stall();
    send_idle = 1'b0;
    release_input();
    hold_off_cycles = 150;
    while (!sink_holding) @(posedge clk);
    send_frame(8'h82, 1'b1, ENC_16, 64'd80, $urandom(), 80);
  endtask

  // leaves the parser inside a payload that never ends, so run it last
  task automatic test_max_length();
    send_frame(8'h80, 1'b1, ENC_64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom(), 24);
  endtask

  initial begin : run
    int unsigned waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_frames(1270, 1'b1);
    test_output_stall();
    test_random_frames(1610, 1'b0);
    test_max_length();
    release_input();
    waited = 0;
    while (decoded_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (decoded_results.size() != 0) begin
      $error("%0d results never arrived", decoded_results.size());
      mismatches++;
    end
    repeat (10) @(posedge clk);
    $display("Covered %0d frames, %0d bytes in, %0d results checked (%0d headers).",
             frames_sent, bytes_sent, results_checked, header_results);
    $display("Included a long output stall and a frame with all-ones 64-bit length.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
